// ----- rtl/tx_descriptor_batch_validator_assert.svh -----
// assertion macros used by the port-level checker file
`ifndef TX_DESCRIPTOR_BATCH_VALIDATOR_ASSERT_SVH
`define TX_DESCRIPTOR_BATCH_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define TXDV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define TXDV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/txdv_pkg.sv -----
// shared types and constants of the transmit descriptor batch validator
`default_nettype none

package txdv_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DESC  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_PKT_DONE  = 3'd1,
        ST_FRAG_HELD = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FRAG_STOP = 3'd4,
        ST_IGNORED   = 3'd5,
        ST_SUMMARY   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        REG_CHUNK_SIZE  = 4'd0,
        REG_META_LEN    = 4'd1,
        REG_AREA_SIZE   = 4'd2,
        REG_MAX_FRAGS   = 4'd3
    } reg_idx_t;

    typedef struct packed {
        logic [16:0] chunk_bytes;
        logic [8:0]  metadata_length;
        logic [47:0] buffer_area_size;
        logic [4:0]  max_fragments;
    } cfg_t;

    localparam logic [16:0] CHUNK_RESET = 17'd4096;
    localparam logic [4:0]  MAX_FRAGS_RESET = 5'd17;
    localparam int unsigned HW_LIMIT = 256;

endpackage

`default_nettype wire

// ----- rtl/tx_descriptor_batch_validator.sv -----
// top level: transmit descriptor batch validator with stream ports
// an accepted input item is held in the input register; its result is then loaded into
//   the output register, which holds it until the receiver takes it
// throughput: one item per cycle while the result stream does not stall; an input register
//   and an output register, with all checks and counter updates in the single logic level between them
// each input item gives exactly one result item
// reset: asynchronous, active low; no batch open, counters zero, registers at defaults
`default_nettype none

module tx_descriptor_batch_validator #(
    parameter int unsigned BATCH_CEILING = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // batch_limit[8:0], desc_addr[72:9], desc_len[104:73],
                                    // desc_options[136:105], zero pad
    input  logic [1:0]   s_tuser,   // command
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // slot_index[7:0], packet_descs[16:8],
                                    // release_count[25:17], invalid_total[57:26], zero pad
    output logic [2:0]   m_tuser,   // status
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    import txdv_pkg::*;

    // batch limit saturates at the build limit and at the slot count
    localparam int unsigned LIMIT_CAP =
        (BATCH_CEILING < HW_LIMIT) ? BATCH_CEILING : HW_LIMIT;
    localparam logic [8:0]  LIMIT_CAP_V = 9'(LIMIT_CAP);

    // configuration registers
    cfg_t cfg_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [8:0]  in_limit_reg;
    logic [63:0] in_addr_reg;
    logic [31:0] in_len_reg;
    logic [31:0] in_opts_reg;

    // batch state
    logic [4:0]  frag_cnt_reg,  frag_cnt_next;
    logic [8:0]  entry_cnt_reg, entry_cnt_next;
    logic [8:0]  complete_reg,  complete_next;
    logic [8:0]  consumed_reg,  consumed_next;
    logic        stopped_reg,   stopped_next;
    logic [8:0]  limit_reg,     limit_next;
    logic [31:0] invalid_reg,   invalid_next;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg, out_status_next;
    logic [7:0]  out_slot_reg,   out_slot_next;
    logic [8:0]  out_pdesc_reg,  out_pdesc_next;
    logic [8:0]  out_release_reg, out_release_next;
    logic [31:0] out_invalid_reg;

    logic        advance;
    logic        fire;
    logic        desc_ok;
    logic [4:0]  frag_inc;
    logic [8:0]  lim_sat;

    // the output register frees when empty or taken; the input register frees on advance
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, out_invalid_reg, out_release_reg, out_pdesc_reg, out_slot_reg};

    txdv_desc_check u_check (
        .cfg          (cfg_reg),
        .desc_addr    (in_addr_reg),
        .desc_len     (in_len_reg),
        .desc_options (in_opts_reg),
        .desc_ok      (desc_ok)
    );

    // register writes, always accepted and applied at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_bytes      <= CHUNK_RESET;
            cfg_reg.metadata_length  <= 9'd0;
            cfg_reg.buffer_area_size <= 48'd0;
            cfg_reg.max_fragments    <= MAX_FRAGS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHUNK_SIZE: cfg_reg.chunk_bytes      <= cfg_data[16:0];
                REG_META_LEN:   cfg_reg.metadata_length  <= cfg_data[8:0];
                REG_AREA_SIZE:  cfg_reg.buffer_area_size <= cfg_data;
                REG_MAX_FRAGS:  cfg_reg.max_fragments    <= cfg_data[4:0];
                default:        ; // writes beyond the register list are dropped
            endcase
        end
    end

    // input register: payload loads on accept, no reset needed for it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_limit_reg <= s_tdata[8:0];
            in_addr_reg  <= s_tdata[72:9];
            in_len_reg   <= s_tdata[104:73];
            in_opts_reg  <= s_tdata[136:105];
        end
    end

    // per-item decision: batch state update and the result fields
    always_comb
    begin
        frag_cnt_next    = frag_cnt_reg;
        entry_cnt_next   = entry_cnt_reg;
        complete_next    = complete_reg;
        consumed_next    = consumed_reg;
        stopped_next     = stopped_reg;
        limit_next       = limit_reg;
        invalid_next     = invalid_reg;
        out_status_next  = ST_IGNORED;
        out_slot_next    = 8'd0;
        out_release_next = 9'd0;
        frag_inc         = frag_cnt_reg + 5'd1;
        lim_sat          = (in_limit_reg > LIMIT_CAP_V) ? LIMIT_CAP_V : in_limit_reg;

        unique case (in_cmd_reg)
            CMD_START:
            begin
                // an open batch is dropped without a summary
                frag_cnt_next   = 5'd0;
                entry_cnt_next  = 9'd0;
                complete_next   = 9'd0;
                consumed_next   = 9'd0;
                limit_next      = lim_sat;
                stopped_next    = 1'b0;
                out_status_next = ST_STARTED;
            end
            CMD_DESC:
            begin
                // descriptors outside an open, running batch or past its limit are ignored
                if (!stopped_reg && (entry_cnt_reg < limit_reg))
                begin
                    out_slot_next = entry_cnt_reg[7:0];
                    consumed_next = consumed_reg + 9'd1;
                    if (!desc_ok)
                    begin
                        invalid_next    = invalid_reg + 32'd1;
                        stopped_next    = 1'b1;
                        out_status_next = ST_INVALID;
                    end
                    else if (!in_opts_reg[0])
                    begin
                        // last fragment closes the packet
                        complete_next   = complete_reg + {4'd0, frag_cnt_reg} + 9'd1;
                        frag_cnt_next   = 5'd0;
                        entry_cnt_next  = entry_cnt_reg + 9'd1;
                        out_status_next = ST_PKT_DONE;
                    end
                    else if (frag_inc >= cfg_reg.max_fragments)
                    begin
                        // packet too long: its fragments are consumed but not counted
                        frag_cnt_next   = 5'd0;
                        stopped_next    = 1'b1;
                        out_status_next = ST_FRAG_STOP;
                    end
                    else
                    begin
                        frag_cnt_next   = frag_inc;
                        entry_cnt_next  = entry_cnt_reg + 9'd1;
                        out_status_next = ST_FRAG_HELD;
                    end
                end
            end
            CMD_END:
            begin
                // trailing partial fragments are rewound from the consumer advance
                out_status_next  = ST_SUMMARY;
                out_release_next = consumed_reg - {4'd0, frag_cnt_reg};
                frag_cnt_next    = 5'd0;
                entry_cnt_next   = 9'd0;
                complete_next    = 9'd0;
                consumed_next    = 9'd0;
                stopped_next     = 1'b1;
                limit_next       = 9'd0;
            end
            default: ; // unknown command: ignored, no state change
        endcase

        // the summary reports the totals from before the batch is cleared
        out_pdesc_next = (in_cmd_reg == CMD_END) ? complete_reg : complete_next;
    end

    // batch state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_cnt_reg  <= 5'd0;
            entry_cnt_reg <= 9'd0;
            complete_reg  <= 9'd0;
            consumed_reg  <= 9'd0;
            stopped_reg   <= 1'b1;
            limit_reg     <= 9'd0;
            invalid_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                frag_cnt_reg  <= frag_cnt_next;
                entry_cnt_reg <= entry_cnt_next;
                complete_reg  <= complete_next;
                consumed_reg  <= consumed_next;
                stopped_reg   <= stopped_next;
                limit_reg     <= limit_next;
                invalid_reg   <= invalid_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg  <= out_status_next;
            out_slot_reg    <= out_slot_next;
            out_pdesc_reg   <= out_pdesc_next;
            out_release_reg <= out_release_next;
            out_invalid_reg <= invalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/txdv_desc_check.sv -----
// aligned-chunk validity check of one descriptor
`default_nettype none

module txdv_desc_check (
    input  txdv_pkg::cfg_t cfg,
    input  logic [63:0]    desc_addr,
    input  logic [31:0]    desc_len,
    input  logic [31:0]    desc_options,
    output logic           desc_ok
);
    import txdv_pkg::*;

    logic [63:0] meta_ext;
    logic [63:0] base;
    logic [16:0] offset;
    logic [33:0] span;
    logic        below_meta;
    logic        over_chunk;
    logic        beyond_area;
    logic        bad_options;

    always_comb
    begin
        meta_ext    = {55'd0, cfg.metadata_length};
        below_meta  = desc_addr < meta_ext;
        base        = desc_addr - meta_ext;
        offset      = base[16:0] & (cfg.chunk_bytes - 17'd1);
        // end of frame inside the chunk, metadata included
        span        = {17'd0, offset} + {2'd0, desc_len} + {25'd0, cfg.metadata_length};
        over_chunk  = span > {17'd0, cfg.chunk_bytes};
        beyond_area = base >= {16'd0, cfg.buffer_area_size};
        bad_options = desc_options[31:2] != 30'd0;
        desc_ok     = (desc_len != 32'd0) && !below_meta && !over_chunk
                      && !beyond_area && !bad_options;
    end

endmodule

`default_nettype wire

// ----- rtl/txdv_checker.sv -----
// port-level checks of the batch validator and their binding
`default_nettype none

`include "tx_descriptor_batch_validator_assert.svh"

module txdv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import txdv_pkg::*;

    // a stalled result keeps its kind and payload
    `TXDV_ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // with no result pending the block always takes an item
    `TXDV_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // consumer advance is reported on the summary only
    `TXDV_ASSERT_NOW(a_release_only_summary, clk, rst_n,
        m_tvalid && (m_tuser != ST_SUMMARY), m_tdata[25:17] == 9'd0)

    // start, ignored and summary results carry no slot
    `TXDV_ASSERT_NOW(a_slot_zero, clk, rst_n,
        m_tvalid && ((m_tuser == ST_STARTED) || (m_tuser == ST_IGNORED)
        || (m_tuser == ST_SUMMARY)), m_tdata[7:0] == 8'd0)

endmodule

bind tx_descriptor_batch_validator txdv_checker u_txdv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- test/tx_descriptor_batch_validator_check.sv -----
// checker for the descriptor batch validator: predicts each result item and compares
`timescale 1ns / 100ps

module tx_descriptor_batch_validator_check #(
    parameter int unsigned BATCH_CEILING = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    output int           faults,
    output int           in_flight,
    output int           results_checked
);
    import txdv_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot;
        logic [8:0]  pkt_descs;
        logic [8:0]  release_cnt;
        logic [31:0] invalid_total;
    } verdict_t;

    // register copies
    logic [16:0] chunk;
    logic [8:0]  meta_len;
    logic [47:0] area;
    logic [4:0]  frag_cap;

    // batch state
    int unsigned frags;
    int unsigned entries;
    int unsigned complete_descs;
    int unsigned consumed;
    bit          stopped;
    int unsigned limit;
    logic [31:0] invalid_cnt;

    verdict_t verdict_q[$];

    function automatic bit desc_fits(input logic [63:0] addr, input logic [31:0] len,
                                     input logic [31:0] opts);
        logic [63:0] base;
        logic [63:0] offset;
        if (len == 0)
            return 1'b0;
        if (addr < meta_len)
            return 1'b0;
        base   = addr - meta_len;
        offset = base & {47'b0, chunk - 17'd1};
        if (offset + len + meta_len > chunk)
            return 1'b0;
        if (base >= {16'b0, area})
            return 1'b0;
        if (opts[31:2] != 0)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_batch();
        frags          = 0;
        entries        = 0;
        complete_descs = 0;
        consumed       = 0;
    endtask

    // advances the batch state by one input item and returns the result it causes
    task automatic judge_item(input logic [1:0] cmd, input logic [8:0] lim,
                              input logic [63:0] addr, input logic [31:0] len,
                              input logic [31:0] opts, output verdict_t v);
        int unsigned capped;
        v = '0;
        v.status = ST_IGNORED;
        case (cmd)
            CMD_START: begin
                capped = 32'(lim);
                if (capped > BATCH_CEILING)
                    capped = BATCH_CEILING;
                if (capped > HW_LIMIT)
                    capped = HW_LIMIT;
                clear_batch();
                limit    = capped;
                stopped  = 1'b0;
                v.status = ST_STARTED;
            end
            CMD_DESC: begin
                if (!stopped && entries < limit) begin
                    v.slot = entries[7:0];
                    consumed++;
                    if (!desc_fits(addr, len, opts)) begin
                        invalid_cnt++;
                        stopped  = 1'b1;
                        v.status = ST_INVALID;
                    end else if (!opts[0]) begin
                        complete_descs += frags + 1;
                        frags = 0;
                        entries++;
                        v.status = ST_PKT_DONE;
                    end else begin
                        frags++;
                        if (frags >= frag_cap) begin
                            frags    = 0;
                            stopped  = 1'b1;
                            v.status = ST_FRAG_STOP;
                        end else begin
                            entries++;
                            v.status = ST_FRAG_HELD;
                        end
                    end
                end
            end
            CMD_END: begin
                v.status        = ST_SUMMARY;
                v.release_cnt   = 9'(consumed - frags);
                v.pkt_descs     = complete_descs[8:0];
                v.invalid_total = invalid_cnt;
                clear_batch();
                stopped = 1'b1;
                limit   = 0;
            end
            default: ;
        endcase
        if (cmd != CMD_END) begin
            v.pkt_descs     = complete_descs[8:0];
            v.invalid_total = invalid_cnt;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        verdict_t due;
        verdict_t got;
        verdict_t fresh;
        if (!rst_n) begin
            chunk       = CHUNK_RESET;
            meta_len    = '0;
            area        = '0;
            frag_cap    = MAX_FRAGS_RESET;
            clear_batch();
            stopped     = 1'b1;
            limit       = 0;
            invalid_cnt = '0;
            verdict_q.delete();
            faults          = 0;
            in_flight       <= 0;
            results_checked <= 0;
        end else begin
            // results first, so a result can never match the item of its own edge
            if (m_tvalid && m_tready) begin
                got.status        = status_t'(m_tuser);
                got.slot          = m_tdata[7:0];
                got.pkt_descs     = m_tdata[16:8];
                got.release_cnt   = m_tdata[25:17];
                got.invalid_total = m_tdata[57:26];
                if (verdict_q.size() == 0) begin
                    if (faults < 10)
                        $display("unexpected result: status %0d slot %0d descs %0d release %0d",
                                 got.status, got.slot, got.pkt_descs, got.release_cnt);
                    faults++;
                end else begin
                    due = verdict_q.pop_front();
                    if (got !== due) begin
                        if (faults < 10)
                            $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                     due.status, due.slot, due.pkt_descs, due.release_cnt,
                                     due.invalid_total, got.status, got.slot, got.pkt_descs,
                                     got.release_cnt, got.invalid_total);
                        faults++;
                    end
                end
                results_checked <= results_checked + 1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHUNK_SIZE: chunk    = cfg_data[16:0];
                    REG_META_LEN:   meta_len = cfg_data[8:0];
                    REG_AREA_SIZE:  area     = cfg_data;
                    REG_MAX_FRAGS:  frag_cap = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                judge_item(s_tuser, s_tdata[8:0], s_tdata[72:9], s_tdata[104:73],
                           s_tdata[136:105], fresh);
                verdict_q.push_back(fresh);
            end
            in_flight <= verdict_q.size();
        end
    end

endmodule

// ----- test/tx_descriptor_batch_validator_tb.sv -----
// testbench top: stimulus, idling, hold-off and verdict for the descriptor batch validator
`timescale 1ns / 100ps

module tx_descriptor_batch_validator_tb;
    import txdv_pkg::*;

    localparam int unsigned BATCH_CAP   = 256;
    localparam int unsigned HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int unsigned PHASE_ITEMS = 130;    // random items per idling phase

    // command code outside the defined set, must be ignored
    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
    // descriptor option bits
    localparam logic [31:0] OPT_CONT = 32'h1;
    localparam logic [31:0] OPT_META = 32'h2;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;    // batch_limit, desc_addr, desc_len, desc_options, zero pad
    logic [1:0]   s_tuser;    // command
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;    // slot_index, packet_descs, release_count, invalid_total, pad
    logic [2:0]   m_tuser;    // status
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_index;
    logic [47:0]  cfg_data;

    int faults;
    int in_flight;
    int results_checked;

    // idling controls, read by the sender task and the receiver process
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned holds_asked   = 0;

    // stimulus-side copy of the settings, only used to shape descriptors
    int unsigned cur_chunk = 4096;
    int unsigned cur_meta  = 0;
    logic [63:0] cur_area  = '0;

    int unsigned items_sent    = 0;
    int unsigned settings_made = 0;
    int unsigned batches_run   = 0;
    int unsigned quiet_cycles  = 0;

    always #4 clk = ~clk;

    tx_descriptor_batch_validator #(
        .BATCH_CEILING(BATCH_CAP)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tx_descriptor_batch_validator_check #(
        .BATCH_CEILING(BATCH_CAP)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .faults         (faults),
        .in_flight      (in_flight),
        .results_checked(results_checked)
    );

    // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
    initial
    begin
        int unsigned holds_granted;
        int unsigned hold_left;
        holds_granted = 0;
        hold_left     = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_granted != holds_asked)
            begin
                holds_granted = holds_asked;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offers one item, with a random idle gap ahead of it; returns at the accepting edge
    task automatic send_item(input logic [1:0] cmd, input logic [8:0] lim,
                             input logic [63:0] addr, input logic [31:0] len,
                             input logic [31:0] opts);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, opts, len, addr, lim};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // waits until every result is back and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (4) @(posedge clk);
    endtask

    // cfg_valid stays high between back-to-back writes
    task automatic write_reg(input reg_idx_t idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [16:0] chunk, input logic [8:0] meta,
                                  input logic [47:0] area, input logic [4:0] frags);
        settle();
        write_reg(REG_CHUNK_SIZE, 48'(chunk));
        write_reg(REG_META_LEN, 48'(meta));
        write_reg(REG_AREA_SIZE, area);
        write_reg(REG_MAX_FRAGS, 48'(frags));
        cfg_valid <= 1'b0;
        cur_chunk = 32'(chunk);
        cur_meta  = 32'(meta);
        cur_area  = 64'(area);
        settings_made++;
    endtask

    // power-of-two chunk, buffer area at least four chunks, so well-formed descriptors exist
    task automatic apply_random_settings();
        logic [16:0] chunk;
        logic [8:0]  meta;
        logic [47:0] area;
        logic [4:0]  frags;
        case ($urandom_range(3))
            0:       chunk = 17'd2048;
            1:       chunk = 17'd65536;
            default: chunk = 17'd2048 << $urandom_range(5, 0);
        endcase
        case ($urandom_range(4))
            0:       meta = 9'd0;
            1:       meta = 9'd256;
            default: meta = 9'($urandom_range(256, 0));
        endcase
        if ($urandom_range(4) == 0)
            area = '1;
        else
        begin
            area = {16'($urandom_range(65535, 0)), $urandom};
            area = area >> $urandom_range(30, 0);
            if (area < (48'(chunk) << 2))
                area = (48'(chunk) << 2) + $urandom_range(4095, 0);
        end
        case ($urandom_range(5))
            0:       frags = 5'd1;
            1:       frags = 5'd17;
            default: frags = 5'($urandom_range(8, 2));
        endcase
        apply_settings(chunk, meta, area, frags);
    endtask

    // a descriptor that passes every check under the current settings
    task automatic send_good_desc(input bit cont);
        int unsigned room;
        int unsigned off;
        int unsigned len;
        logic [63:0] base;
        room = cur_chunk - cur_meta;
        off  = ($urandom_range(3) == 0) ? 0 : $urandom_range(room - 1, 0);
        len  = ($urandom_range(9) == 0) ? room - off : $urandom_range(room - off, 1);
        base = (rand64() % (cur_area / cur_chunk)) * cur_chunk + off;
        send_item(CMD_DESC, 9'($urandom), base + cur_meta, len,
                  {30'b0, 1'($urandom), cont});
    endtask

    // a descriptor that breaks one check, or is plain noise
    task automatic send_bad_desc();
        int unsigned room;
        logic [63:0] addr;
        logic [31:0] len;
        logic [31:0] opts;
        room = cur_chunk - cur_meta;
        addr = (rand64() % (cur_area / cur_chunk)) * cur_chunk + cur_meta;
        len  = $urandom_range(room, 1);
        opts = $urandom_range(3, 0);
        case ($urandom_range(5))
            0: len = '0;
            1:
            begin
                // below the metadata, falls back to zero length without metadata
                if (cur_meta != 0)
                    addr = 64'($urandom_range(cur_meta - 1, 0));
                else
                    len = '0;
            end
            2: len = room + $urandom_range(5000, 1);    // runs past the chunk end
            3: addr = cur_area + (rand64() % 4096) + cur_meta;
            4: opts = opts | (32'h4 << $urandom_range(29, 0));
            default:
            begin
                addr = rand64();
                len  = $urandom;
                opts = $urandom;
            end
        endcase
        send_item(CMD_DESC, 9'($urandom), addr, len, opts);
    endtask

    // start, a run of mostly well-formed descriptors, usually an end
    task automatic run_batch(input int unsigned bad_pct);
        int unsigned lim;
        int unsigned count;
        int unsigned k;
        case ($urandom_range(19))
            0:       lim = 0;
            1:       lim = $urandom_range(511, 256);
            2:       lim = $urandom_range(40, 13);
            default: lim = $urandom_range(12, 1);
        endcase
        send_item(CMD_START, 9'(lim), rand64(), $urandom, $urandom);
        // a few descriptors past the limit when the batch is short
        count = (lim > 40) ? $urandom_range(40, 16) : lim + $urandom_range(2, 0);
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < bad_pct)
                send_bad_desc();
            else
                send_good_desc($urandom_range(99) < 40);
        end
        // an open batch left behind gets dropped by the next start
        if ($urandom_range(15) != 0)
            send_item(CMD_END, 9'($urandom), rand64(), $urandom, $urandom);
        batches_run++;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned target;
        int unsigned k;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty buffer area, so every descriptor is refused
        send_item(CMD_END, '0, '0, '0, '0);                    // summary with no batch open
        send_item(CMD_DESC, '0, 64'h1000, 32'd64, '0);         // outside any batch
        send_item(CMD_UNKNOWN, '1, '1, '1, '1);
        send_item(CMD_START, 9'd2, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'h1000, 32'd64, '0);
        send_item(CMD_DESC, '0, 64'h1000, 32'd64, '0);         // batch already stopped

        // smallest chunk, largest metadata and area, short fragment limit
        apply_settings(17'd2048, 9'd256, '1, 5'd3);
        send_item(CMD_START, 9'h1FF, '0, '0, '0);             // limit saturates
        send_item(CMD_DESC, '0, 64'd256, 32'd1792, '0);        // exactly fills the chunk
        send_item(CMD_DESC, '0, 64'd2304, 32'd16, OPT_CONT | OPT_META);
        send_item(CMD_DESC, '0, 64'd4352, 32'd16, OPT_CONT);
        send_item(CMD_DESC, '0, 64'd6400, 32'd16, OPT_CONT);   // hits the fragment limit
        send_item(CMD_END, '0, '0, '0, '0);
        send_item(CMD_START, 9'd0, '0, '0, '0);                // zero limit
        send_item(CMD_DESC, '0, 64'd256, 32'd16, '0);
        send_item(CMD_START, 9'd5, '0, '0, '0);                // restart while open
        send_item(CMD_DESC, '0, 64'd255, 32'd16, '0);          // below the metadata
        send_item(CMD_START, 9'd5, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'd256, 32'd0, '0);           // zero length
        send_item(CMD_START, 9'd5, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'd256, 32'd1793, '0);        // one byte over the chunk
        send_item(CMD_START, 9'd5, '0, '0, '0);
        send_item(CMD_DESC, '0, '1, '1, '0);                   // beyond the buffer area
        send_item(CMD_START, 9'd5, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'd256, 32'd16, 32'hFFFF_FFFC);   // unknown option bits
        send_item(CMD_END, '0, '0, '0, '0);

        // odd chunk size and fragment limit of zero: first continuation stops the batch
        apply_settings(17'h1FFFF, 9'd0, 48'd1 << 20, 5'd0);
        send_item(CMD_START, 9'd3, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'h3_0000, 32'd100, OPT_CONT);
        // zero chunk size refuses everything
        apply_settings(17'd0, 9'd0, 48'd1 << 20, 5'd17);
        send_item(CMD_START, 9'd3, '0, '0, '0);
        send_item(CMD_DESC, '0, 64'h100, 32'd16, '0);
        send_item(CMD_END, '0, '0, '0, '0);

        // random batches under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 73; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 8;  stall_pct = 8;  end
            endcase
            apply_random_settings();
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(3) == 0)
                    apply_random_settings();
                // stray items between batches
                case ($urandom_range(19))
                    0: send_item(CMD_UNKNOWN, 9'($urandom), rand64(), $urandom, $urandom);
                    1: send_item(CMD_DESC, 9'($urandom), rand64(), $urandom, $urandom);
                    2: send_item(CMD_END, 9'($urandom), rand64(), $urandom, $urandom);
                    default: ;
                endcase
                run_batch(7);
            end
        end

        // back pressure: a full batch offered flat out while the receiver holds off
        apply_settings(17'd4096, 9'd64, '1, 5'd17);
        send_idle_pct = 0;
        stall_pct     = 0;
        holds_asked++;
        send_item(CMD_START, 9'd256, '0, '0, '0);
        for (k = 0; k < BATCH_CAP + 2; k++)
            send_good_desc($urandom_range(9) == 0);
        send_item(CMD_END, '0, '0, '0, '0);
        batches_run++;

        // drain, then let the input and output registers empty
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (8) @(posedge clk);

        $display("run: %0d items in %0d batches under %0d register settings, with back pressure",
                 items_sent, batches_run, settings_made);
        $display("run: %0d results compared, %0d mismatches", results_checked, faults);
        if (faults == 0 && in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
